// ----- hw/rtl/pvsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Polyphonic voice synthesizer package
// Shared widths, item codes, oscillator constants and the voice record.
// ----------------------------------------------------------------------------
package pvsm_pkg;

  localparam int unsigned VOICE_COUNT_DEF = 16;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned WAVE_W    = 3;
  localparam int unsigned PHASE_W   = 24;
  localparam int unsigned STEP_W    = 23;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned LEVEL_W   = 15;
  localparam int unsigned ELAPSED_W = 17;
  localparam int unsigned NOISE_W   = 32;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned OSC_W     = 18;

  localparam logic [MODE_W-1:0] MODE_SPAWN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MUTE  = 2'd2;

  localparam logic [WAVE_W-1:0] WAVE_SINE   = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAW    = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_NOISE  = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_TRI    = 3'd4;

  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned SINE_SHIFT      = PHASE_W - SINE_TABLE_BITS;

  localparam int unsigned MUL_W = 31;
  localparam logic [MUL_W-1:0] SIN_A1 = 31'd1686629713;
  localparam logic [MUL_W-1:0] SIN_A3 = 31'd693598668;
  localparam logic [MUL_W-1:0] SIN_A5 = 31'd85569305;
  localparam logic [MUL_W-1:0] SIN_A7 = 31'd5026995;

  localparam logic [NOISE_W-1:0] SEED_STEP  = 32'h9E3779B9;
  localparam logic [NOISE_W-1:0] SEED_RESET = 32'h13572468;

  // Mix word sized for the largest voice count.
  localparam int unsigned MAG_W  = 36;
  localparam int unsigned MIX_W  = MAG_W + 1;
  localparam int unsigned HALF_W = MAG_W / 2;
  localparam logic [MUL_W-1:0] MIX_SCALE = 31'd150000;

  localparam int unsigned DIV_NUM_W = 54;
  localparam int unsigned DIV_DEN_W = 38;
  localparam int unsigned DIV_Q_W   = 24;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_Q_W);
  localparam logic [DIV_DEN_W-1:0] MIX_DEN_BASE = 38'd5 << 30;

  localparam logic [TIME_W-1:0] ENV_ONE = 16'd32768;

  typedef struct packed {
    logic [WAVE_W-1:0]           shape;
    logic [PHASE_W-1:0]          phase;
    logic [STEP_W-1:0]           start_step;
    logic [STEP_W-1:0]           end_step;
    logic signed [ELAPSED_W-1:0] elapsed;
    logic [TIME_W-1:0]           length;
    logic [LEVEL_W-1:0]          level;
    logic [TIME_W-1:0]           rise;
    logic [TIME_W-1:0]           fall;
    logic [NOISE_W-1:0]          noise;
  } voice_t;

endpackage

// ----- hw/rtl/pvsm_in_if.sv -----
// ----------------------------------------------------------------------------
// Synthesizer request channel
// Valid/ready channel that carries one spawn, tick or mute request.
// ----------------------------------------------------------------------------
interface pvsm_in_if;
  import pvsm_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [WAVE_W-1:0]   wave;
  logic [STEP_W-1:0]   start_increment;
  logic [STEP_W-1:0]   end_increment;
  logic [TIME_W-1:0]   duration;
  logic [LEVEL_W-1:0]  amplitude;
  logic [TIME_W-1:0]   attack;
  logic [TIME_W-1:0]   release_req;
  logic [TIME_W-1:0]   delay;
  logic [TIME_W-1:0]   mute_samples;

  modport source (
    output valid, mode, wave, start_increment, end_increment, duration,
           amplitude, attack, release_req, delay, mute_samples,
    input  ready
  );
  modport sink (
    input  valid, mode, wave, start_increment, end_increment, duration,
           amplitude, attack, release_req, delay, mute_samples,
    output ready
  );
endinterface

// ----- hw/rtl/pvsm_out_if.sv -----
// ----------------------------------------------------------------------------
// Synthesizer sample channel
// Valid/ready channel that carries one mixed audio sample.
// ----------------------------------------------------------------------------
interface pvsm_out_if;
  import pvsm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

// ----- hw/rtl/polyphonic_voice_synth_mixer_unit.sv -----
// ----------------------------------------------------------------------------
// Polyphonic voice synthesizer and mixer
// Oscillators with sweeps and envelopes, soft-clipped into one 16-bit sample.
// ----------------------------------------------------------------------------
// Requests arrive on in_i. A spawn request claims the first free voice or
// steals the one that has run longest. A tick request renders one sample and
// returns it on out_o. A mute request silences the next N ticks. Spawn, mute
// and ignored requests return nothing.
// in_i is ready only while the sequencer is idle. A spawn writes a free voice
// directly and first scans every voice for the longest run when it must steal.
// A mute only loads the mute count, and a muted tick goes straight to emit. A
// rendered tick walks every voice: it skips an idle voice, only counts down the
// delay of a delaying voice, and runs a sounding voice through sweep, envelope,
// gain, oscillator (with polynomial steps for a sine) and mix, with divisions
// for a sweep and an envelope slope; the final mix and emit follow. One 24-step
// restoring divider and one 31x31 multiplier are shared by all of this.
// The sample sits in an output register; the block takes new requests while
// it waits, and only a second finished tick waits for the register to empty.
// Reset frees all voices, clears the mute count and reloads the noise seed counter.
// ----------------------------------------------------------------------------
module polyphonic_voice_synth_mixer_unit #(
  parameter int unsigned VOICE_COUNT = pvsm_pkg::VOICE_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pvsm_in_if.sink    in_i,
  pvsm_out_if.source out_o
);
  import pvsm_pkg::*;

  localparam int unsigned IDX_W   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned STATE_W = 5;

  localparam logic [STATE_W-1:0] S_IDLE     = 5'd0;
  localparam logic [STATE_W-1:0] S_SCAN_RD  = 5'd1;
  localparam logic [STATE_W-1:0] S_SCAN_CMP = 5'd2;
  localparam logic [STATE_W-1:0] S_SPAWN_WR = 5'd3;
  localparam logic [STATE_W-1:0] S_V_RD     = 5'd4;
  localparam logic [STATE_W-1:0] S_V_LD     = 5'd5;
  localparam logic [STATE_W-1:0] S_SW_MUL   = 5'd6;
  localparam logic [STATE_W-1:0] S_SW_DIV   = 5'd7;
  localparam logic [STATE_W-1:0] S_DIV      = 5'd8;
  localparam logic [STATE_W-1:0] S_SW_DONE  = 5'd9;
  localparam logic [STATE_W-1:0] S_ENV      = 5'd10;
  localparam logic [STATE_W-1:0] S_ENV_DONE = 5'd11;
  localparam logic [STATE_W-1:0] S_GAIN_MUL = 5'd12;
  localparam logic [STATE_W-1:0] S_GAIN     = 5'd13;
  localparam logic [STATE_W-1:0] S_SIN_U2   = 5'd14;
  localparam logic [STATE_W-1:0] S_SIN_T5   = 5'd15;
  localparam logic [STATE_W-1:0] S_SIN_T3   = 5'd16;
  localparam logic [STATE_W-1:0] S_SIN_T1   = 5'd17;
  localparam logic [STATE_W-1:0] S_SIN_S    = 5'd18;
  localparam logic [STATE_W-1:0] S_MIX_MUL  = 5'd19;
  localparam logic [STATE_W-1:0] S_MIX      = 5'd20;
  localparam logic [STATE_W-1:0] S_FIN_LO   = 5'd21;
  localparam logic [STATE_W-1:0] S_FIN_HI   = 5'd22;
  localparam logic [STATE_W-1:0] S_FIN_SUM  = 5'd23;
  localparam logic [STATE_W-1:0] S_FIN_DONE = 5'd24;
  localparam logic [STATE_W-1:0] S_EMIT     = 5'd25;

  logic [STATE_W-1:0]         state_q, state_d, ret_q, ret_d;
  logic [IDX_W-1:0]           k_q, k_d, pick_q, pick_d;
  logic [VOICE_COUNT-1:0]     busy_q, busy_d;
  logic [NOISE_W-1:0]         seed_q, seed_d;
  logic [TIME_W-1:0]          mute_q, mute_d;
  logic                       out_valid_q, out_valid_d;
  logic [DIV_CNT_W-1:0]       dcnt_q, dcnt_d;

  voice_t                     v_q, v_d, spawn_q, spawn_d;
  logic signed [ELAPSED_W-1:0] best_q, best_d;
  logic [TIME_W-1:0]          t_q, t_d, env_q, env_d;
  logic [STEP_W-1:0]          step_q, step_d;
  logic                       neg_q, neg_d;
  logic [LEVEL_W-1:0]         gain_q, gain_d;
  logic signed [OSC_W-1:0]    osc_q, osc_d;
  logic [MUL_W-1:0]           u2_q, u2_d;
  logic signed [MIX_W-1:0]    mix_q, mix_d;
  logic [MAG_W-1:0]           plo_q, plo_d;
  logic [DIV_DEN_W-1:0]       rem_q, rem_d, den_q, den_d;
  logic [DIV_Q_W-1:0]         dnum_q, dnum_d, quo_q, quo_d;
  logic signed [SAMPLE_W-1:0] res_q, res_d, out_sample_q, out_sample_d;
  logic [2*MUL_W-1:0]         prod_q;

  logic                       in_fire, last_k, any_free;
  logic [IDX_W-1:0]           free_idx;
  logic [NOISE_W-1:0]         seed_sum, nz;
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  voice_t                     ram_wdata, ram_rdata;
  logic [MUL_W-1:0]           mul_a, mul_b, poly;
  logic                       div_go;
  logic [DIV_NUM_W-1:0]       div_num;
  logic [DIV_DEN_W-1:0]       div_den;
  logic [STATE_W-1:0]         div_ret;
  logic [DIV_DEN_W:0]         r2;
  logic                       ge;
  logic signed [STEP_W:0]     diff;
  logic [PHASE_W-1:0]         sin_p, tri_d;
  logic [STEP_W-1:0]          sin_x;
  logic [MUL_W-1:0]           sin_u;
  logic [31:0]                rnd;
  logic [SAMPLE_W:0]          sin_r;
  logic [SAMPLE_W:0]          osc_mag;
  logic signed [MIX_W-1:0]    term;
  logic [MAG_W-1:0]           mag;
  logic [DIV_NUM_W-1:0]       fin_num;
  logic [ELAPSED_W-1:0]       t_next;

  pvsm_ram #(
    .WIDTH ($bits(voice_t)),
    .DEPTH (VOICE_COUNT)
  ) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (k_q),
    .rdata_o (ram_rdata)
  );

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.sample = out_sample_q;
  assign last_k   = (k_q == IDX_W'(VOICE_COUNT - 1));
  assign seed_sum = seed_q + SEED_STEP;

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Oscillator, sweep, mix and divider helpers from the working registers.
  always_comb begin
    sin_p   = (v_q.phase >> SINE_SHIFT) << SINE_SHIFT;
    sin_x   = sin_p[22] ? (23'h400000 - {1'b0, sin_p[21:0]}) : {1'b0, sin_p[21:0]};
    sin_u   = {sin_x, 8'd0};
    tri_d   = v_q.phase[23] ? (v_q.phase - 24'h800000) : (24'h800000 - v_q.phase);
    nz      = v_q.noise ^ (v_q.noise << 13);
    nz      = nz ^ (nz >> 17);
    nz      = nz ^ (nz << 5);
    rnd     = {1'b0, prod_q[60:30]} + 32'd16384;
    sin_r   = (rnd[31:15] > 17'd32767) ? 17'd32767 : rnd[31:15];
    osc_mag = osc_q[OSC_W-1] ? (SAMPLE_W+1)'(-osc_q) : osc_q[SAMPLE_W:0];
    diff    = $signed({1'b0, v_q.end_step}) - $signed({1'b0, v_q.start_step});
    term    = MIX_W'(prod_q[29:0]);
    mag     = mix_q[MIX_W-1] ? MAG_W'(-mix_q) : MAG_W'(mix_q);
    fin_num = DIV_NUM_W'(plo_q) + (DIV_NUM_W'(prod_q[MAG_W-1:0]) << HALF_W);
    t_next  = {1'b0, t_q} + 17'd1;
    r2      = {rem_q, dnum_q[DIV_Q_W-1]};
    ge      = (r2 >= {1'b0, den_q});
  end

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    k_d          = k_q;
    pick_d       = pick_q;
    busy_d       = busy_q;
    seed_d       = seed_q;
    mute_d       = mute_q;
    out_valid_d  = out_valid_q;
    out_sample_d = out_sample_q;
    dcnt_d       = dcnt_q;
    v_d          = v_q;
    spawn_d      = spawn_q;
    best_d       = best_q;
    t_d          = t_q;
    env_d        = env_q;
    step_d       = step_q;
    neg_d        = neg_q;
    gain_d       = gain_q;
    osc_d        = osc_q;
    u2_d         = u2_q;
    mix_d        = mix_q;
    plo_d        = plo_q;
    rem_d        = rem_q;
    den_d        = den_q;
    dnum_d       = dnum_q;
    quo_d        = quo_q;
    res_d        = res_q;
    ram_we       = 1'b0;
    ram_waddr    = k_q;
    ram_wdata    = v_q;
    mul_a        = '0;
    mul_b        = '0;
    poly         = '0;
    div_go       = 1'b0;
    div_num      = '0;
    div_den      = '0;
    div_ret      = S_IDLE;

    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_i.mode)
            MODE_SPAWN: begin
              spawn_d.shape      = in_i.wave;
              spawn_d.phase      = '0;
              spawn_d.start_step = in_i.start_increment;
              spawn_d.end_step   = in_i.end_increment;
              spawn_d.elapsed    = ELAPSED_W'(0) - {1'b0, in_i.delay};
              spawn_d.length     = in_i.duration;
              spawn_d.level      = in_i.amplitude;
              spawn_d.rise       = in_i.attack;
              spawn_d.fall       = in_i.release_req;
              spawn_d.noise      = seed_sum | NOISE_W'(1);
              seed_d             = seed_sum;
              k_d                = '0;
              if (any_free) begin
                pick_d  = free_idx;
                state_d = S_SPAWN_WR;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            MODE_TICK: begin
              if (mute_q != '0) begin
                mute_d  = mute_q - 1'b1;
                res_d   = '0;
                state_d = S_EMIT;
              end else begin
                mix_d   = '0;
                k_d     = '0;
                state_d = S_V_RD;
              end
            end
            MODE_MUTE: begin
              mute_d = in_i.mute_samples;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if ((k_q == '0) || (ram_rdata.elapsed > best_q)) begin
          best_d = ram_rdata.elapsed;
          pick_d = k_q;
        end
        if (last_k) begin
          state_d = S_SPAWN_WR;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_SPAWN_WR: begin
        ram_we         = 1'b1;
        ram_waddr      = pick_q;
        ram_wdata      = spawn_q;
        busy_d[pick_q] = 1'b1;
        state_d        = S_IDLE;
      end
      S_V_RD: begin
        if (busy_q[k_q]) begin
          state_d = S_V_LD;
        end else if (last_k) begin
          state_d = S_FIN_LO;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_V_LD: begin
        v_d = ram_rdata;
        t_d = ram_rdata.elapsed[TIME_W-1:0];
        if (ram_rdata.elapsed < 0) begin
          ram_we            = 1'b1;
          ram_wdata         = ram_rdata;
          ram_wdata.elapsed = ram_rdata.elapsed + 1'b1;
          if (last_k) begin
            state_d = S_FIN_LO;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_V_RD;
          end
        end else begin
          state_d = S_SW_MUL;
        end
      end
      S_SW_MUL: begin
        if ((v_q.end_step != '0) && (v_q.length != '0)) begin
          neg_d   = diff[STEP_W];
          mul_a   = MUL_W'(diff[STEP_W] ? -diff : diff);
          mul_b   = MUL_W'(t_q);
          state_d = S_SW_DIV;
        end else begin
          step_d  = v_q.start_step;
          state_d = S_ENV;
        end
      end
      S_SW_DIV: begin
        div_go  = 1'b1;
        div_num = prod_q[DIV_NUM_W-1:0];
        div_den = DIV_DEN_W'(v_q.length);
        div_ret = S_SW_DONE;
      end
      S_DIV: begin
        rem_d  = ge ? DIV_DEN_W'(r2 - {1'b0, den_q}) : r2[DIV_DEN_W-1:0];
        quo_d  = {quo_q[DIV_Q_W-2:0], ge};
        dnum_d = dnum_q << 1;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DIV_CNT_W'(DIV_Q_W - 1)) begin
          state_d = ret_q;
        end
      end
      S_SW_DONE: begin
        step_d  = neg_q ? (v_q.start_step - quo_q[STEP_W-1:0])
                        : (v_q.start_step + quo_q[STEP_W-1:0]);
        state_d = S_ENV;
      end
      S_ENV: begin
        v_d.phase = v_q.phase + PHASE_W'(step_q);
        if (t_q < v_q.rise) begin
          div_go  = 1'b1;
          div_num = DIV_NUM_W'(t_q) << 15;
          div_den = DIV_DEN_W'(v_q.rise);
          div_ret = S_ENV_DONE;
        end else if (({1'b0, t_q} + {1'b0, v_q.fall}) > {1'b0, v_q.length}) begin
          if (v_q.fall != '0) begin
            div_go  = 1'b1;
            div_num = DIV_NUM_W'(v_q.length - t_q) << 15;
            div_den = DIV_DEN_W'(v_q.fall);
            div_ret = S_ENV_DONE;
          end else begin
            env_d   = '0;
            state_d = S_GAIN_MUL;
          end
        end else begin
          env_d   = ENV_ONE;
          state_d = S_GAIN_MUL;
        end
      end
      S_ENV_DONE: begin
        env_d   = (quo_q > DIV_Q_W'(ENV_ONE)) ? ENV_ONE : quo_q[TIME_W-1:0];
        state_d = S_GAIN_MUL;
      end
      S_GAIN_MUL: begin
        mul_a   = MUL_W'(env_q);
        mul_b   = MUL_W'(v_q.level);
        state_d = S_GAIN;
      end
      S_GAIN: begin
        gain_d  = prod_q[29:15];
        state_d = S_MIX_MUL;
        case (v_q.shape)
          WAVE_SINE: begin
            mul_a   = sin_u;
            mul_b   = sin_u;
            state_d = S_SIN_U2;
          end
          WAVE_SQUARE: begin
            osc_d = v_q.phase[23] ? -18'sd32768 : 18'sd32768;
          end
          WAVE_SAW: begin
            osc_d = $signed({2'b0, v_q.phase[23:8]}) - 18'sd32768;
          end
          WAVE_TRI: begin
            osc_d = $signed({1'b0, tri_d[23:7]}) - 18'sd32768;
          end
          default: begin
            v_d.noise = nz;
            osc_d     = OSC_W'($signed(nz[31:16]));
          end
        endcase
      end
      S_SIN_U2: begin
        u2_d    = prod_q[60:30];
        mul_a   = prod_q[60:30];
        mul_b   = SIN_A7;
        state_d = S_SIN_T5;
      end
      S_SIN_T5: begin
        poly    = SIN_A5 - prod_q[60:30];
        mul_a   = u2_q;
        mul_b   = poly;
        state_d = S_SIN_T3;
      end
      S_SIN_T3: begin
        poly    = SIN_A3 - prod_q[60:30];
        mul_a   = u2_q;
        mul_b   = poly;
        state_d = S_SIN_T1;
      end
      S_SIN_T1: begin
        poly    = SIN_A1 - prod_q[60:30];
        mul_a   = sin_u;
        mul_b   = poly;
        state_d = S_SIN_S;
      end
      S_SIN_S: begin
        osc_d   = sin_p[23] ? -$signed({1'b0, sin_r}) : $signed({1'b0, sin_r});
        state_d = S_MIX_MUL;
      end
      S_MIX_MUL: begin
        mul_a   = MUL_W'(osc_mag);
        mul_b   = MUL_W'(gain_q);
        state_d = S_MIX;
      end
      S_MIX: begin
        mix_d             = osc_q[OSC_W-1] ? (mix_q - term) : (mix_q + term);
        ram_we            = 1'b1;
        ram_wdata         = v_q;
        ram_wdata.elapsed = t_next;
        if (t_next >= {1'b0, v_q.length}) begin
          busy_d[k_q] = 1'b0;
        end
        if (last_k) begin
          state_d = S_FIN_LO;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_V_RD;
        end
      end
      S_FIN_LO: begin
        mul_a   = MUL_W'(mag[HALF_W-1:0]);
        mul_b   = MIX_SCALE;
        state_d = S_FIN_HI;
      end
      S_FIN_HI: begin
        plo_d   = prod_q[MAG_W-1:0];
        mul_a   = MUL_W'(mag[MAG_W-1:HALF_W]);
        mul_b   = MIX_SCALE;
        state_d = S_FIN_SUM;
      end
      S_FIN_SUM: begin
        div_go  = 1'b1;
        div_num = fin_num;
        div_den = MIX_DEN_BASE + (DIV_DEN_W'(mag) << 1);
        div_ret = S_FIN_DONE;
      end
      S_FIN_DONE: begin
        if (mix_q[MIX_W-1]) begin
          res_d = (quo_q >= DIV_Q_W'(32768)) ? -16'sd32768 : -$signed(SAMPLE_W'(quo_q));
        end else begin
          res_d = (quo_q > DIV_Q_W'(32767)) ? 16'sd32767 : $signed(SAMPLE_W'(quo_q));
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_sample_d = res_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (div_go) begin
      rem_d   = DIV_DEN_W'(div_num[DIV_NUM_W-1:DIV_Q_W]);
      dnum_d  = div_num[DIV_Q_W-1:0];
      den_d   = div_den;
      quo_d   = '0;
      dcnt_d  = '0;
      ret_d   = div_ret;
      state_d = S_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      k_q         <= '0;
      pick_q      <= '0;
      busy_q      <= '0;
      seed_q      <= SEED_RESET;
      mute_q      <= '0;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      k_q         <= k_d;
      pick_q      <= pick_d;
      busy_q      <= busy_d;
      seed_q      <= seed_d;
      mute_q      <= mute_d;
      out_valid_q <= out_valid_d;
      dcnt_q      <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sample_q <= out_sample_d;
    v_q          <= v_d;
    spawn_q      <= spawn_d;
    best_q       <= best_d;
    t_q          <= t_d;
    env_q        <= env_d;
    step_q       <= step_d;
    neg_q        <= neg_d;
    gain_q       <= gain_d;
    osc_q        <= osc_d;
    u2_q         <= u2_d;
    mix_q        <= mix_d;
    plo_q        <= plo_d;
    rem_q        <= rem_d;
    den_q        <= den_d;
    dnum_q       <= dnum_d;
    quo_q        <= quo_d;
    res_q        <= res_d;
    prod_q       <= mul_a * mul_b;
  end

  // The divider only runs when its quotient fits the fixed step count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_EMIT)
    else $error("sample presented outside the emit step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_fire) |-> $stable(mute_q))
    else $error("mute count changed without a request");
endmodule

// ----- hw/rtl/pvsm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pvsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- sim/pvsm_tb_if.sv -----
// ----------------------------------------------------------------------------
// Synthesizer request record for simulation
// Package with the request record that the bench drives and models.
// ----------------------------------------------------------------------------
package pvsm_tb_pkg;
  import pvsm_pkg::*;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [WAVE_W-1:0]  wave;
    logic [STEP_W-1:0]  start_inc;
    logic [STEP_W-1:0]  end_inc;
    logic [TIME_W-1:0]  duration;
    logic [LEVEL_W-1:0] amplitude;
    logic [TIME_W-1:0]  attack;
    logic [TIME_W-1:0]  rel;
    logic [TIME_W-1:0]  delay;
    logic [TIME_W-1:0]  mute;
  } request_t;
endpackage

// ----- sim/tb_polyphonic_voice_synth_mixer_unit.sv -----
// ----------------------------------------------------------------------------
// Polyphonic voice synthesizer testbench
// Drives spawn, tick, mute and unused-mode requests with random gaps, predicts
// every sample with a bit-exact voice model and compares each one in order.
// ----------------------------------------------------------------------------
module tb_polyphonic_voice_synth_mixer_unit;
  import pvsm_pkg::*;
  import pvsm_tb_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  class sample_scoreboard;
    bit          busy[16];
    logic [2:0]  shape[16];
    logic [23:0] phase[16];
    longint      start_s[16], end_s[16], len[16], level[16], rise[16], fall[16];
    longint      elapsed[16];
    logic [31:0] noise[16];
    logic [31:0] seed;
    int          mute_left;
    logic signed [15:0] pending[$];
    int          errors;

    function void reset_state();
      foreach (busy[k]) begin
        busy[k] = 0;
        elapsed[k] = 0;
      end
      seed = SEED_RESET;
      mute_left = 0;
      errors = 0;
    endfunction

    function longint sine_val(logic [23:0] p);
      logic [1:0]  q;
      logic [21:0] x;
      longint      u, u2, t, s;
      p = (p >> SINE_SHIFT) << SINE_SHIFT;
      q = p[23:22];
      x = p[21:0];
      u = q[0] ? (64'h400000 - x) : x;
      u = u << 8;
      u2 = (u * u) >> 30;
      t = SIN_A7;
      t = SIN_A5 - ((u2 * t) >> 30);
      t = SIN_A3 - ((u2 * t) >> 30);
      t = SIN_A1 - ((u2 * t) >> 30);
      s = (u * t) >> 30;
      s = (s + 16384) >> 15;
      if (s > 32767) s = 32767;
      return q[1] ? -s : s;
    endfunction

    function longint wave_val(int k);
      logic [31:0] x;
      logic [23:0] p;
      longint      d;
      p = phase[k];
      case (shape[k])
        WAVE_SINE:   return sine_val(p);
        WAVE_SQUARE: return p < 24'h800000 ? 32768 : -32768;
        WAVE_SAW:    return longint'(p >> 8) - 32768;
        WAVE_TRI: begin
          d = p >= 24'h800000 ? p - 24'h800000 : 24'h800000 - p;
          return (d >> 7) - 32768;
        end
        default: begin
          x = noise[k];
          x ^= x << 13;
          x ^= x >> 17;
          x ^= x << 5;
          noise[k] = x;
          return longint'($signed(x[31:16]));
        end
      endcase
    endfunction

    function longint envelope(int k);
      longint t, e;
      t = elapsed[k];
      if (t < rise[k]) e = (t * 32768) / rise[k];
      else if (t > len[k] - fall[k]) e = fall[k] > 0 ? ((len[k] - t) * 32768) / fall[k] : 0;
      else e = 32768;
      if (e < 0) e = 0;
      if (e > 32768) e = 32768;
      return e;
    endfunction

    function void note_request(request_t r);
      int     pick;
      longint mix, step, gain, mag, q;
      bit     found;
      case (r.mode)
        MODE_SPAWN: begin
          pick = 0;
          found = 0;
          for (int k = 0; k < 16; k++)
            if (!found && !busy[k]) begin
              pick = k;
              found = 1;
            end
          if (!found)
            for (int k = 1; k < 16; k++)
              if (elapsed[k] > elapsed[pick]) pick = k;
          busy[pick] = 1;
          shape[pick] = r.wave;
          phase[pick] = 0;
          start_s[pick] = r.start_inc;
          end_s[pick] = r.end_inc;
          len[pick] = r.duration;
          level[pick] = r.amplitude;
          rise[pick] = r.attack;
          fall[pick] = r.rel;
          elapsed[pick] = -longint'(r.delay);
          seed += SEED_STEP;
          noise[pick] = seed | 32'd1;
        end
        MODE_TICK: begin
          if (mute_left > 0) begin
            mute_left--;
            pending.push_back(0);
          end else begin
            mix = 0;
            for (int k = 0; k < 16; k++) begin
              if (!busy[k]) continue;
              if (elapsed[k] < 0) begin
                elapsed[k]++;
                continue;
              end
              step = start_s[k];
              if (end_s[k] > 0 && len[k] > 0)
                step += ((end_s[k] - step) * elapsed[k]) / len[k];
              phase[k] = phase[k] + step[23:0];
              gain = (envelope(k) * level[k]) >>> 15;
              mix += wave_val(k) * gain;
              elapsed[k]++;
              if (elapsed[k] >= len[k]) busy[k] = 0;
            end
            mag = mix < 0 ? -mix : mix;
            q = (150000 * mag) / ((longint'(5) << 30) + 2 * mag);
            if (mix < 0) q = -q;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            pending.push_back(q[15:0]);
          end
        end
        MODE_MUTE: mute_left = r.mute;
        default: ;
      endcase
    endfunction

    function void check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  pvsm_in_if  req_ch ();
  pvsm_out_if smp_ch ();
  sample_scoreboard board;
  int  cycles = 0;
  bit  calm = 0;

  polyphonic_voice_synth_mixer_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_ch.sink), .out_o(smp_ch.source)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 10000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && smp_ch.valid && smp_ch.ready) board.check_sample(smp_ch.sample);

  always @(negedge clk_i)
    smp_ch.ready <= rst_ni && (calm || $urandom_range(99) >= 31);

  task automatic send(request_t r);
    while (!calm && $urandom_range(99) < 31) begin
      req_ch.valid <= 0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1;
    req_ch.mode <= r.mode;
    req_ch.wave <= r.wave;
    req_ch.start_increment <= r.start_inc;
    req_ch.end_increment <= r.end_inc;
    req_ch.duration <= r.duration;
    req_ch.amplitude <= r.amplitude;
    req_ch.attack <= r.attack;
    req_ch.release_req <= r.rel;
    req_ch.delay <= r.delay;
    req_ch.mute_samples <= r.mute;
    do @(posedge clk_i); while (!req_ch.ready);
    board.note_request(r);
    @(negedge clk_i);
  endtask

  function automatic request_t noise_req(logic [1:0] mode);
    request_t r;
    r.mode = mode;
    r.wave = WAVE_W'($urandom);
    r.start_inc = STEP_W'($urandom);
    r.end_inc = $urandom_range(3) == 0 ? '0 : STEP_W'($urandom);
    r.duration = TIME_W'($urandom);
    r.amplitude = LEVEL_W'($urandom);
    r.attack = TIME_W'($urandom);
    r.rel = TIME_W'($urandom);
    r.delay = TIME_W'($urandom);
    r.mute = TIME_W'($urandom);
    return r;
  endfunction

  function automatic request_t short_voice();
    request_t r;
    r = noise_req(MODE_SPAWN);
    r.duration = TIME_W'($urandom_range(1, 60));
    r.attack = TIME_W'($urandom_range(0, 30));
    r.rel = TIME_W'($urandom_range(0, 30));
    r.delay = TIME_W'($urandom_range(0, 10));
    return r;
  endfunction

  function automatic request_t tick_req();
    request_t r;
    r = noise_req(MODE_TICK);
    return r;
  endfunction

  initial begin
    request_t r;
    board = new();
    board.reset_state();
    req_ch.valid = 0;
    req_ch.mode = MODE_TICK;
    req_ch.wave = 0;
    req_ch.start_increment = 0;
    req_ch.end_increment = 0;
    req_ch.duration = 0;
    req_ch.amplitude = 0;
    req_ch.attack = 0;
    req_ch.release_req = 0;
    req_ch.delay = 0;
    req_ch.mute_samples = 0;
    smp_ch.ready = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Every wave code at full scale and extreme steps, then zero duration and mutes.
    send(tick_req());
    for (int w = 0; w < 8; w++) begin
      r = short_voice();
      r.wave = WAVE_W'(w);
      r.amplitude = 15'h7FFF;
      r.attack = 0;
      r.delay = 0;
      r.start_inc = w[0] ? 23'h7FFFFF : 23'h1234;
      r.end_inc = w[1] ? 0 : 23'h7FFFFF;
      send(r);
    end
    r = short_voice();
    r.duration = 0;
    r.delay = 0;
    send(r);
    for (int i = 0; i < 4; i++) send(tick_req());
    r = noise_req(MODE_MUTE);
    r.mute = 2;
    send(r);
    r.mute = 3;
    send(r);
    send(noise_req(MODE_UNUSED));
    for (int i = 0; i < 5; i++) send(tick_req());
    r.mute = 0;
    send(r);

    for (int n = 0; n < 1200; n++) begin
      calm = (n >= 400 && n < 550);
      case ($urandom_range(19))
        0, 1, 2, 3:   send(short_voice());
        4:            send(noise_req(MODE_SPAWN));
        5: begin
          r = noise_req(MODE_MUTE);
          if ($urandom_range(3) != 0) r.mute = TIME_W'($urandom_range(0, 6));
          send(r);
        end
        6:            send(noise_req(MODE_UNUSED));
        default:      send(tick_req());
      endcase
    end
    calm = 0;
    req_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// ----- polyphonic_voice_synth_mixer_unit.f -----
hw/rtl/pvsm_pkg.sv
hw/rtl/pvsm_in_if.sv
hw/rtl/pvsm_out_if.sv
hw/rtl/pvsm_ram.sv
hw/rtl/polyphonic_voice_synth_mixer_unit.sv
sim/pvsm_tb_if.sv
sim/tb_polyphonic_voice_synth_mixer_unit.sv
